/* rtl/cv3_pkg.sv */
// Package: shared constants, types and register codes of the 3x3 convolution block.
`timescale 1ns / 1ps
`default_nettype none

package cv3_pkg;

    // Sizes of the line stores and the kernel coefficients
    localparam int MAX_WIDTH    = 2048;
    localparam int COEFF_BITS   = 8;
    localparam int HEIGHT_LIMIT = 2048;
    localparam int MIN_SIZE     = 3;

    // Pixel and kernel layout
    localparam int CHANNELS  = 3;
    localparam int CH_W      = 8;
    localparam int PIX_W     = CHANNELS * CH_W;
    localparam int TAPS      = 9;
    localparam int KROW_W    = 3 * COEFF_BITS;
    localparam int SIZE_W    = 12;

    // Configuration port
    localparam int CFG_W     = (KROW_W > SIZE_W) ? KROW_W : SIZE_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_TOP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MIDDLE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_BOTTOM = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT  = 3'd4;

    localparam logic [SIZE_W-1:0] FRAME_SIZE_RESET = 12'd512;

    // Position counters and size compares
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int CMP_W  = (COL_W + 1 > SIZE_W) ? COL_W + 1 : SIZE_W;
    localparam int ROW_W  = $clog2(HEIGHT_LIMIT);
    localparam int RCMP_W = (ROW_W + 1 > SIZE_W) ? ROW_W + 1 : SIZE_W;

    // Arithmetic widths: signed coeff times zero-extended pixel, then two adder levels
    localparam int PROD_W = COEFF_BITS + CH_W + 1;
    localparam int RSUM_W = PROD_W + 2;
    localparam int SUM_W  = PROD_W + 4;

    // Magnitude limit and replacement value
    localparam int                SAT_LIMIT = 255;
    localparam logic [CH_W-1:0]   SAT_VALUE = 8'd254;

    typedef struct packed {
        logic [2:0][KROW_W-1:0] row;    // row[0] top, row[2] bottom
    } kernel_t;

    typedef struct packed {
        logic [TAPS-1:0][PIX_W-1:0] px; // px[r*3+c], r=0 top row, c=0 left column
        logic                       frame_end;
    } win_t;

    typedef struct packed {
        logic [CHANNELS-1:0][CH_W-1:0] ch; // ch[0] red
        logic                          frame_end;
    } res_t;

endpackage

`default_nettype wire

/* rtl/cv3_pix_if.sv */
// Interfaces: input pixel channel and result channel with valid/ready handshake.
`timescale 1ns / 1ps
`default_nettype none

interface cv3_pix_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;

    modport source (output valid, output pixel_red, output pixel_green, output pixel_blue,
                    input ready);
    modport sink   (input valid, input pixel_red, input pixel_green, input pixel_blue,
                    output ready);
endinterface

interface cv3_res_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_red;
    logic [7:0] out_green;
    logic [7:0] out_blue;
    logic       frame_end;

    modport source (output valid, output out_red, output out_green, output out_blue,
                    output frame_end, input ready);
    modport sink   (input valid, input out_red, input out_green, input out_blue,
                    input frame_end, output ready);
endinterface

`default_nettype wire

/* rtl/cv3_ram.sv */
// Generic simple dual-port RAM with registered read.
`timescale 1ns / 1ps
`default_nettype none

module cv3_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     clk,
    input  wire logic                     wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]         wr_data,
    input  wire logic                     rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic      [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
    end

    // Registered read, held while no read is issued
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem_reg[rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/cv3_window.sv */
// Line buffer, raster position counters and 3x3 window assembly (two pipeline stages).
`timescale 1ns / 1ps
`default_nettype none

module cv3_window (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire logic [cv3_pkg::PIX_W-1:0]  in_pixel,
    input  wire logic [cv3_pkg::SIZE_W-1:0] frame_width,
    input  wire logic [cv3_pkg::SIZE_W-1:0] frame_height,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output cv3_pkg::win_t               out_win
);
    import cv3_pkg::*;

    logic              accept;
    logic              en1;
    logic              en2;
    logic              s1_move;

    logic [COL_W-1:0]  col_reg;
    logic [COL_W-1:0]  col_next;
    logic [ROW_W-1:0]  row_reg;
    logic [ROW_W-1:0]  row_next;

    logic [CMP_W-1:0]  width_ext;
    logic [CMP_W-1:0]  width_eff;
    logic [RCMP_W-1:0] height_ext;
    logic [RCMP_W-1:0] height_eff;
    logic              last_col;
    logic              last_row;
    logic              produce;

    logic              s1_valid_reg;
    logic [COL_W-1:0]  s1_col_reg;
    logic [PIX_W-1:0]  s1_pixel_reg;
    logic              s1_produce_reg;
    logic              s1_fend_reg;

    logic [2*PIX_W-1:0] ram_rd_data;
    logic [2*PIX_W-1:0] ram_wr_data;
    logic [PIX_W-1:0]   line_top;
    logic [PIX_W-1:0]   line_mid;

    logic [PIX_W-1:0]  win_reg [6];
    logic              s2_valid_reg;
    win_t              s2_win_reg;
    win_t              s2_win_next;

    // Stage enables: a stage loads when empty or when its content moves on
    assign en2      = !s2_valid_reg || out_ready;
    assign en1      = !s1_valid_reg || en2;
    assign in_ready = en1;
    assign accept   = in_valid && en1;
    assign s1_move  = s1_valid_reg && en2;

    // Clamp the frame size to its legal range
    always_comb
    begin
        width_ext  = CMP_W'(frame_width);
        height_ext = RCMP_W'(frame_height);
        if (width_ext < CMP_W'(MIN_SIZE))
            width_eff = CMP_W'(MIN_SIZE);
        else if (width_ext > CMP_W'(MAX_WIDTH))
            width_eff = CMP_W'(MAX_WIDTH);
        else
            width_eff = width_ext;
        if (height_ext < RCMP_W'(MIN_SIZE))
            height_eff = RCMP_W'(MIN_SIZE);
        else if (height_ext > RCMP_W'(HEIGHT_LIMIT))
            height_eff = RCMP_W'(HEIGHT_LIMIT);
        else
            height_eff = height_ext;
    end

    // Position of the arriving pixel and the counters for the next one
    always_comb
    begin
        last_col = (CMP_W'(col_reg) + CMP_W'(1)) >= width_eff;
        last_row = (RCMP_W'(row_reg) + RCMP_W'(1)) >= height_eff;
        produce  = (row_reg >= ROW_W'(2)) && (col_reg >= COL_W'(2));
        if (last_col)
        begin
            col_next = '0;
            row_next = last_row ? '0 : row_reg + ROW_W'(1);
        end
        else
        begin
            col_next = col_reg + COL_W'(1);
            row_next = row_reg;
        end
    end

    // Advance the raster counters on each accepted transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // Both line stores share one word: upper row in the high half, lower row in the low half
    assign line_top    = ram_rd_data[2*PIX_W-1:PIX_W];
    assign line_mid    = ram_rd_data[PIX_W-1:0];
    assign ram_wr_data = {line_mid, s1_pixel_reg};

    cv3_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_line_ram (
        .clk     (clk),
        .wr_en   (s1_move),
        .wr_addr (s1_col_reg),
        .wr_data (ram_wr_data),
        .rd_en   (accept),
        .rd_addr (col_reg),
        .rd_data (ram_rd_data)
    );

    // Stage 1: hold the pixel while the line store read completes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else if (en1)
            s1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg     <= col_reg;
            s1_pixel_reg   <= in_pixel;
            s1_produce_reg <= produce;
            s1_fend_reg    <= last_col && last_row;
        end
    end

    // Form the neighborhood: two stored columns plus the column just read
    always_comb
    begin
        s2_win_next.px[0]     = win_reg[0];
        s2_win_next.px[1]     = win_reg[3];
        s2_win_next.px[2]     = line_top;
        s2_win_next.px[3]     = win_reg[1];
        s2_win_next.px[4]     = win_reg[4];
        s2_win_next.px[5]     = line_mid;
        s2_win_next.px[6]     = win_reg[2];
        s2_win_next.px[7]     = win_reg[5];
        s2_win_next.px[8]     = s1_pixel_reg;
        s2_win_next.frame_end = s1_fend_reg;
    end

    // Shift the column window as each pixel leaves stage 1
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= line_top;
            win_reg[4] <= line_mid;
            win_reg[5] <= s1_pixel_reg;
        end
    end

    // Stage 2: keep only interior pixels, drop border ones
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else if (en2)
            s2_valid_reg <= s1_valid_reg && s1_produce_reg;
    end

    always_ff @(posedge clk)
    begin
        if (s1_move)
            s2_win_reg <= s2_win_next;
    end

    assign out_valid = s2_valid_reg;
    assign out_win   = s2_win_reg;

endmodule

`default_nettype wire

/* rtl/cv3_mac.sv */
// Multiply-accumulate pipeline: products, row sums, total with magnitude limit.
`timescale 1ns / 1ps
`default_nettype none

module cv3_mac (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    input  wire cv3_pkg::win_t   in_win,
    input  wire cv3_pkg::kernel_t kernel,
    output logic                 out_valid,
    input  wire logic            out_ready,
    output cv3_pkg::res_t        out_res
);
    import cv3_pkg::*;

    logic en1;
    logic en2;
    logic en3;

    logic signed [COEFF_BITS-1:0] coef [TAPS];

    logic                     m1_valid_reg;
    logic                     m1_fend_reg;
    logic signed [PROD_W-1:0] m1_prod_reg  [CHANNELS][TAPS];
    logic signed [PROD_W-1:0] m1_prod_next [CHANNELS][TAPS];

    logic                     m2_valid_reg;
    logic                     m2_fend_reg;
    logic signed [RSUM_W-1:0] m2_rsum_reg  [CHANNELS][3];
    logic signed [RSUM_W-1:0] m2_rsum_next [CHANNELS][3];

    logic                     m3_valid_reg;
    res_t                     m3_res_reg;
    res_t                     m3_res_next;

    logic signed [SUM_W-1:0]  total [CHANNELS];
    logic        [SUM_W-1:0]  mag   [CHANNELS];

    // Stage enables
    assign en3      = !m3_valid_reg || out_ready;
    assign en2      = !m2_valid_reg || en3;
    assign en1      = !m1_valid_reg || en2;
    assign in_ready = en1;

    // Unpack the coefficients: left one in the low bits of each row
    always_comb
    begin
        for (int r = 0; r < 3; r++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                coef[r*3+c] = kernel.row[r][c*COEFF_BITS +: COEFF_BITS];
            end
        end
    end

    // Stage M1: one product per tap and channel
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            for (int t = 0; t < TAPS; t++)
            begin
                m1_prod_next[ch][t] = PROD_W'(coef[t])
                    * PROD_W'($signed({1'b0, in_win.px[t][ch*CH_W +: CH_W]}));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m1_valid_reg <= 1'b0;
        else if (en1)
            m1_valid_reg <= in_valid;
    end

    always_ff @(posedge clk)
    begin
        if (en1 && in_valid)
        begin
            m1_prod_reg <= m1_prod_next;
            m1_fend_reg <= in_win.frame_end;
        end
    end

    // Stage M2: sum each kernel row
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            for (int r = 0; r < 3; r++)
            begin
                m2_rsum_next[ch][r] = RSUM_W'(m1_prod_reg[ch][r*3])
                                    + RSUM_W'(m1_prod_reg[ch][r*3+1])
                                    + RSUM_W'(m1_prod_reg[ch][r*3+2]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m2_valid_reg <= 1'b0;
        else if (en2)
            m2_valid_reg <= m1_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en2 && m1_valid_reg)
        begin
            m2_rsum_reg <= m2_rsum_next;
            m2_fend_reg <= m1_fend_reg;
        end
    end

    // Stage M3: total, magnitude, replace anything above the limit
    always_comb
    begin
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            total[ch] = SUM_W'(m2_rsum_reg[ch][0]) + SUM_W'(m2_rsum_reg[ch][1])
                      + SUM_W'(m2_rsum_reg[ch][2]);
            mag[ch]   = total[ch][SUM_W-1] ? -total[ch] : total[ch];
            m3_res_next.ch[ch] = (mag[ch] > SUM_W'(SAT_LIMIT)) ? SAT_VALUE : mag[ch][CH_W-1:0];
        end
        m3_res_next.frame_end = m2_fend_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m3_valid_reg <= 1'b0;
        else if (en3)
            m3_valid_reg <= m2_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en3 && m2_valid_reg)
            m3_res_reg <= m3_res_next;
    end

    assign out_valid = m3_valid_reg;
    assign out_res   = m3_res_reg;

endmodule

`default_nettype wire

/* rtl/convolution_3x3_abs_saturate.sv */
// Top level: configuration registers, window front end and convolution pipeline.
//
// Usage:
//   pix_in carries one RGB pixel per transaction in raster order; res_out carries
//   one filtered pixel per interior input pixel, so a W x H frame yields
//   (W-2) x (H-2) results, frame_end marking the last one of the frame.
//   Each channel is the absolute value of the 3x3 kernel sum; a magnitude above
//   255 is reported as 254.
//   Configuration: cfg_write with cfg_index selects kernel rows 0..2, frame width
//   (3) and frame height (4); write only while the block is idle.
// Timing:
//   One pixel per cycle sustained while the receiver takes results. A result passes
//   through the line store read, window, product, row sum and total stages after
//   the input transaction that completes its neighborhood. The rate is set by the
//   single line store RAM, read and written once per pixel.
// Reset:
//   Clears counters and stage valid bits, kernel to zero, frame size to 512 x 512.
//   Line store contents are not cleared; the first two rows fill them.
// Stall:
//   A stalled receiver holds the result; earlier stages keep filling bubbles, and
//   pix_in.ready drops only once every stage holds a transaction.
`timescale 1ns / 1ps
`default_nettype none

module convolution_3x3_abs_saturate (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    cv3_pix_if.sink                            pix_in,
    cv3_res_if.source                          res_out,
    input  wire logic                          cfg_write,
    input  wire logic [cv3_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [cv3_pkg::CFG_W-1:0]     cfg_data
);
    import cv3_pkg::*;

    kernel_t           kernel_reg;
    logic [SIZE_W-1:0] frame_width_reg;
    logic [SIZE_W-1:0] frame_height_reg;

    logic              win_valid;
    logic              win_ready;
    win_t              win;
    res_t              res;

    // Configuration registers; unknown indexes are ignored
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            kernel_reg       <= '0;
            frame_width_reg  <= FRAME_SIZE_RESET;
            frame_height_reg <= FRAME_SIZE_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                CFG_KERNEL_TOP:    kernel_reg.row[0]  <= cfg_data[KROW_W-1:0];
                CFG_KERNEL_MIDDLE: kernel_reg.row[1]  <= cfg_data[KROW_W-1:0];
                CFG_KERNEL_BOTTOM: kernel_reg.row[2]  <= cfg_data[KROW_W-1:0];
                CFG_FRAME_WIDTH:   frame_width_reg    <= cfg_data[SIZE_W-1:0];
                CFG_FRAME_HEIGHT:  frame_height_reg   <= cfg_data[SIZE_W-1:0];
                default:           ;
            endcase
        end
    end

    cv3_window u_window (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (pix_in.valid),
        .in_ready     (pix_in.ready),
        .in_pixel     ({pix_in.pixel_blue, pix_in.pixel_green, pix_in.pixel_red}),
        .frame_width  (frame_width_reg),
        .frame_height (frame_height_reg),
        .out_valid    (win_valid),
        .out_ready    (win_ready),
        .out_win      (win)
    );

    cv3_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (win_valid),
        .in_ready  (win_ready),
        .in_win    (win),
        .kernel    (kernel_reg),
        .out_valid (res_out.valid),
        .out_ready (res_out.ready),
        .out_res   (res)
    );

    assign res_out.out_red   = res.ch[0];
    assign res_out.out_green = res.ch[1];
    assign res_out.out_blue  = res.ch[2];
    assign res_out.frame_end = res.frame_end;

    // With no window pending, the front end must take a pixel
    a_front_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !win_valid |-> pix_in.ready)
        else $error("front end not ready with empty window stage");

    // With no result pending, the convolution pipeline must take a window
    a_mac_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !res_out.valid |-> win_ready)
        else $error("convolution pipeline stalled with empty output");

    // The convolution pipeline only backs up behind a stalled receiver
    a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
        (win_valid && !win_ready) |-> (res_out.valid && !res_out.ready))
        else $error("convolution pipeline stalled without output back-pressure");

endmodule

`default_nettype wire

/* bench/tb_convolution_3x3_abs_saturate.sv */
// Testbench for the 3x3 RGB convolution block: directed frames, random frames, scoreboard.
`timescale 1ns / 1ps

module tb_convolution_3x3_abs_saturate;
    import cv3_pkg::*;

    localparam int CLK_HALF     = 2;
    localparam int RESET_CYCLES = 8;
    localparam int DRAIN_CYCLES = 12;
    localparam int HOLD_CYCLES  = 300;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int RANDOM_ITEMS = 560;
    localparam int MAX_REPORTS  = 10;

    // Register indexes past the end of the map; writes to them must change nothing
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    typedef enum int {K_WIDE, K_NARROW, K_SPARSE, K_EXTREME} kernel_style_e;
    typedef enum int {P_WIDE, P_DIM, P_EXTREME} pixel_style_e;
    typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_e;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic       frame_end;
    } filtered_px_t;

    typedef struct packed {
        bit                   is_write;
        logic [CFG_IDX_W-1:0] index;
        logic [CFG_W-1:0]     data;
        logic [PIX_W-1:0]     pixel;
        bit                   typed;
        filtered_px_t         result;
    } plan_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_write;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    cv3_pix_if pix_in();
    cv3_res_if res_out();

    convolution_3x3_abs_saturate u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_in    (pix_in),
        .res_out   (res_out),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Filter state mirrored on the bench side
    logic [2:0][KROW_W-1:0] kernel_rows;
    logic [SIZE_W-1:0]      width_reg;
    logic [SIZE_W-1:0]      height_reg;
    logic [PIX_W-1:0]       upper_line [MAX_WIDTH];
    logic [PIX_W-1:0]       lower_line [MAX_WIDTH];
    logic [PIX_W-1:0]       window_col [6];
    int                     col_pos;
    int                     row_pos;

    filtered_px_t expected_px [$];
    plan_row_t    directed_plan [$];

    int src_idle_pct    = 0;
    int rcv_stall_pct   = 0;
    int hold_asked      = 0;
    int fail_count      = 0;
    int results_checked = 0;
    int frames_seen     = 0;
    int items_sent      = 0;
    int phase_count     = 0;
    int cycle_count     = 0;

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #(CLK_HALF) clk = ~clk;
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycle_count, expected_px.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] index,
                                           input logic [CFG_W-1:0] data);
        case (index)
            CFG_KERNEL_TOP:    kernel_rows[0] = data[KROW_W-1:0];
            CFG_KERNEL_MIDDLE: kernel_rows[1] = data[KROW_W-1:0];
            CFG_KERNEL_BOTTOM: kernel_rows[2] = data[KROW_W-1:0];
            CFG_FRAME_WIDTH:   width_reg = data[SIZE_W-1:0];
            CFG_FRAME_HEIGHT:  height_reg = data[SIZE_W-1:0];
            default: ;
        endcase
    endfunction

    // Exact kernel sum of one channel, then magnitude with the over-range replacement
    function automatic logic [7:0] channel_magnitude(input logic [8:0][7:0] taps);
        int acc;
        acc = 0;
        for (int r = 0; r < 3; r++)
            for (int c = 0; c < 3; c++)
                acc += int'($signed(kernel_rows[r][c*COEFF_BITS +: COEFF_BITS]))
                       * int'(taps[r*3+c]);
        if (acc < 0)
            acc = -acc;
        if (acc > SAT_LIMIT)
            return SAT_VALUE;
        return 8'(acc);
    endfunction

    // Advance the filter by one pixel; returns 1 when the pixel completes a neighborhood
    function automatic bit advance_pixel(input logic [PIX_W-1:0] pixel,
                                         output filtered_px_t res);
        int                     width_used;
        int                     height_used;
        logic [PIX_W-1:0]       top_px;
        logic [PIX_W-1:0]       mid_px;
        logic [8:0][PIX_W-1:0]  nbhd;
        logic [8:0][7:0]        taps;
        logic [2:0][7:0]        mags;
        bit                     last_col;
        bit                     last_row;
        bit                     produced;
        width_used  = (width_reg < MIN_SIZE) ? MIN_SIZE :
                      (width_reg > MAX_WIDTH) ? MAX_WIDTH : int'(width_reg);
        height_used = (height_reg < MIN_SIZE) ? MIN_SIZE :
                      (height_reg > HEIGHT_LIMIT) ? HEIGHT_LIMIT : int'(height_reg);
        last_col = (col_pos + 1 >= width_used);
        last_row = (row_pos + 1 >= height_used);

        top_px = upper_line[col_pos];
        mid_px = lower_line[col_pos];
        upper_line[col_pos] = mid_px;
        lower_line[col_pos] = pixel;

        produced = (row_pos >= 2) && (col_pos >= 2);
        res = '0;
        if (produced)
        begin
            for (int r = 0; r < 3; r++)
            begin
                nbhd[r*3]   = window_col[r];
                nbhd[r*3+1] = window_col[3+r];
            end
            nbhd[2] = top_px;
            nbhd[5] = mid_px;
            nbhd[8] = pixel;
            for (int ch = 0; ch < CHANNELS; ch++)
            begin
                for (int t = 0; t < TAPS; t++)
                    taps[t] = nbhd[t][ch*CH_W +: CH_W];
                mags[ch] = channel_magnitude(taps);
            end
            res.red       = mags[0];
            res.green     = mags[1];
            res.blue      = mags[2];
            res.frame_end = last_col && last_row;
        end

        // Shift the window one column left
        for (int r = 0; r < 3; r++)
            window_col[r] = window_col[3+r];
        window_col[3] = top_px;
        window_col[4] = mid_px;
        window_col[5] = pixel;

        if (last_col)
        begin
            col_pos = 0;
            row_pos = last_row ? 0 : row_pos + 1;
        end
        else
            col_pos = col_pos + 1;
        return produced;
    endfunction

    function automatic void set_idle_mode(input idle_mode_e mode);
        case (mode)
            IDLE_NONE:     begin src_idle_pct = 0;  rcv_stall_pct = 0;  end
            IDLE_SENDER:   begin src_idle_pct = 55; rcv_stall_pct = 0;  end
            IDLE_RECEIVER: begin src_idle_pct = 0;  rcv_stall_pct = 55; end
            default:       begin src_idle_pct = 23; rcv_stall_pct = 23; end
        endcase
    endfunction

    function automatic logic [KROW_W-1:0] random_kernel_row(input kernel_style_e style);
        logic [KROW_W-1:0] row;
        int                v;
        row = '0;
        case (style)
            K_WIDE:
                row = KROW_W'($urandom());
            K_NARROW:
                for (int s = 0; s < 3; s++)
                begin
                    v = int'($urandom_range(4)) - 2;
                    row[s*COEFF_BITS +: COEFF_BITS] = v[COEFF_BITS-1:0];
                end
            K_SPARSE:
                row[$urandom_range(2)*COEFF_BITS +: COEFF_BITS] = COEFF_BITS'($urandom());
            default:
                row = ($urandom_range(1) != 0) ? 24'h7F7F7F : 24'h808080;
        endcase
        return row;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel(input pixel_style_e style);
        logic [PIX_W-1:0] px;
        px = '0;
        for (int ch = 0; ch < CHANNELS; ch++)
            case (style)
                P_WIDE:  px[ch*CH_W +: CH_W] = CH_W'($urandom());
                P_DIM:   px[ch*CH_W +: CH_W] = CH_W'($urandom_range(15));
                default: px[ch*CH_W +: CH_W] = ($urandom_range(1) != 0) ? 8'hFF : 8'h00;
            endcase
        return px;
    endfunction

    // Offer one pixel, wait for its transaction, then record what it should produce
    task automatic send_pixel(input logic [PIX_W-1:0] pixel, input bit typed,
                              input filtered_px_t typed_res);
        filtered_px_t predicted;
        bit           produced;
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct)
        begin
            pix_in.valid <= 1'b0;
            @(negedge clk);
        end
        pix_in.valid       <= 1'b1;
        pix_in.pixel_red   <= pixel[7:0];
        pix_in.pixel_green <= pixel[15:8];
        pix_in.pixel_blue  <= pixel[23:16];
        do
            @(posedge clk);
        while (!pix_in.ready);
        produced = advance_pixel(pixel, predicted);
        if (typed)
            expected_px.push_back(typed_res);
        else if (produced)
            expected_px.push_back(predicted);
        items_sent++;
    endtask

    // Drop valid and wait until the block has drained
    task automatic settle();
        @(negedge clk);
        pix_in.valid <= 1'b0;
        while (expected_px.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_register(input logic [CFG_IDX_W-1:0] index,
                                  input logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        apply_register(index, data);
        @(negedge clk);
        cfg_write <= 1'b0;
    endtask

    task automatic run_phase(input int width_val, input int height_val, input int n_items,
                             input kernel_style_e kstyle, input pixel_style_e pstyle,
                             input idle_mode_e mode);
        settle();
        set_idle_mode(mode);
        write_register(CFG_KERNEL_TOP, random_kernel_row(kstyle));
        write_register(CFG_KERNEL_MIDDLE, random_kernel_row(kstyle));
        write_register(CFG_KERNEL_BOTTOM, random_kernel_row(kstyle));
        write_register(CFG_FRAME_WIDTH, CFG_W'(width_val));
        write_register(CFG_FRAME_HEIGHT, CFG_W'(height_val));
        phase_count++;
        repeat (n_items) send_pixel(random_pixel(pstyle), 1'b0, '0);
    endtask

    // Send pixels until the raster position is back at the frame origin
    task automatic finish_frame(input pixel_style_e pstyle);
        while (col_pos != 0 || row_pos != 0)
            send_pixel(random_pixel(pstyle), 1'b0, '0);
    endtask

    task automatic add_write(input logic [CFG_IDX_W-1:0] index, input logic [CFG_W-1:0] data);
        directed_plan.push_back({1'b1, index, data, {PIX_W{1'b0}}, 1'b0, 25'd0});
    endtask

    task automatic add_pixel(input logic [PIX_W-1:0] pixel);
        directed_plan.push_back({1'b0, {CFG_IDX_W{1'b0}}, {CFG_W{1'b0}}, pixel, 1'b0, 25'd0});
    endtask

    task automatic add_checked_pixel(input logic [PIX_W-1:0] pixel, input filtered_px_t res);
        directed_plan.push_back({1'b0, {CFG_IDX_W{1'b0}}, {CFG_W{1'b0}}, pixel, 1'b1, res});
    endtask

    task automatic report_failure(input string what, input filtered_px_t want,
                                  input filtered_px_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
        begin
            $display("%s at cycle %0d: expected r=%02h g=%02h b=%02h end=%0b",
                     what, cycle_count, want.red, want.green, want.blue, want.frame_end);
            $display("    got r=%02h g=%02h b=%02h end=%0b",
                     got.red, got.green, got.blue, got.frame_end);
        end
    endtask

    // Result side: ready pattern, with a long hold whenever the stimulus asks for one
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        res_out.ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_asked != hold_seen)
            begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_out.ready <= 1'b0;
            end
            else
                res_out.ready <= ($urandom_range(99) >= rcv_stall_pct);
        end
    end

    // Scoreboard: compare each result transaction with the oldest expectation
    always @(posedge clk)
    begin
        filtered_px_t got;
        filtered_px_t want;
        if (rst_n && res_out.valid && res_out.ready)
        begin
            got.red       = res_out.out_red;
            got.green     = res_out.out_green;
            got.blue      = res_out.out_blue;
            got.frame_end = res_out.frame_end;
            results_checked++;
            if (got.frame_end === 1'b1)
                frames_seen++;
            if (expected_px.size() == 0)
                report_failure("unexpected result", '0, got);
            else
            begin
                want = expected_px.pop_front();
                if (got.red !== want.red || got.green !== want.green ||
                    got.blue !== want.blue || got.frame_end !== want.frame_end)
                    report_failure("mismatch", want, got);
            end
        end
    end

    // Stimulus
    initial
    begin
        int items_before;
        int random_items;
        int w;
        int h;
        rst_n              = 1'b0;
        cfg_write          = 1'b0;
        cfg_index          = '0;
        cfg_data           = '0;
        pix_in.valid       = 1'b0;
        pix_in.pixel_red   = '0;
        pix_in.pixel_green = '0;
        pix_in.pixel_blue  = '0;
        kernel_rows        = '0;
        width_reg          = FRAME_SIZE_RESET;
        height_reg         = FRAME_SIZE_RESET;
        for (int i = 0; i < 6; i++)
            window_col[i] = '0;
        col_pos      = 0;
        row_pos      = 0;
        random_items = 0;

        repeat (RESET_CYCLES) @(negedge clk);
        rst_n <= 1'b1;

        // Directed frames at 3x3: reset kernel, saturating sums, center tap of -1
        add_write(CFG_FRAME_WIDTH, 24'd3);
        add_write(CFG_FRAME_HEIGHT, 24'd3);
        add_write(CFG_SPARE_LO, 24'hFFFFFF);
        add_write(CFG_SPARE_HI, 24'h7F7F7F);
        for (int i = 0; i < 8; i++)
            add_pixel(i[0] ? 24'h000000 : 24'hFFFFFF);
        add_checked_pixel(24'hFFFFFF, {8'h00, 8'h00, 8'h00, 1'b1});

        add_write(CFG_KERNEL_TOP, 24'h808080);
        add_write(CFG_KERNEL_MIDDLE, 24'h7F7F7F);
        add_write(CFG_KERNEL_BOTTOM, 24'h000000);
        for (int i = 0; i < 8; i++)
            add_pixel(24'hFF00FF);
        add_checked_pixel(24'hFF00FF, {8'hFE, 8'h00, 8'hFE, 1'b1});

        add_write(CFG_KERNEL_TOP, 24'h000000);
        add_write(CFG_KERNEL_MIDDLE, 24'h00FF00);
        add_write(CFG_KERNEL_BOTTOM, 24'h000000);
        add_pixel(24'h010203);
        add_pixel(24'h804020);
        add_pixel(24'h7F7F7F);
        add_pixel(24'h55AA55);
        add_pixel(24'hFE8001);
        add_pixel(24'hAA55AA);
        add_pixel(24'h000000);
        add_pixel(24'hFFFFFF);
        add_checked_pixel(24'h112233, {8'h01, 8'h80, 8'hFE, 1'b1});

        set_idle_mode(IDLE_BOTH);
        foreach (directed_plan[i])
        begin
            if (directed_plan[i].is_write)
            begin
                settle();
                write_register(directed_plan[i].index, directed_plan[i].data);
            end
            else
                send_pixel(directed_plan[i].pixel, directed_plan[i].typed,
                           directed_plan[i].result);
        end

        // Sizes below the minimum clamp to 3x3
        run_phase(0, 2, 27, K_NARROW, P_DIM, IDLE_SENDER);
        finish_frame(P_DIM);

        // Shrink both sizes in the middle of a frame, past the current position
        run_phase(10, 8, 36, K_SPARSE, P_WIDE, IDLE_RECEIVER);
        settle();
        write_register(CFG_FRAME_WIDTH, 24'd4);
        write_register(CFG_FRAME_HEIGHT, 24'd3);
        finish_frame(P_WIDE);
        repeat (24) send_pixel(random_pixel(P_WIDE), 1'b0, '0);
        finish_frame(P_WIDE);

        // Long receiver hold while pixels keep coming, then a full drain mid-frame
        run_phase(24, 12, 100, K_NARROW, P_DIM, IDLE_NONE);
        hold_asked++;
        repeat (100) send_pixel(random_pixel(P_DIM), 1'b0, '0);
        settle();
        repeat (50) send_pixel(random_pixel(P_WIDE), 1'b0, '0);
        finish_frame(P_DIM);

        // Random frames, mostly small
        while (random_items < RANDOM_ITEMS)
        begin
            w = ($urandom_range(7) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 3);
            h = ($urandom_range(7) == 0) ? $urandom_range(20, 9) : $urandom_range(8, 3);
            items_before = items_sent;
            run_phase(w, h, $urandom_range(3 * w * h, 1),
                      kernel_style_e'($urandom_range(3)), pixel_style_e'($urandom_range(2)),
                      idle_mode_e'(phase_count % 4));
            finish_frame(P_WIDE);
            random_items += items_sent - items_before;
        end

        // Sizes above the maximum clamp to 2048; shrink mid-row to close the frame early
        run_phase(4095, 4095, 64, K_NARROW, P_DIM, IDLE_BOTH);
        settle();
        write_register(CFG_FRAME_WIDTH, 24'd3);
        write_register(CFG_FRAME_HEIGHT, 24'd3);
        finish_frame(P_WIDE);

        // Drain and close out
        settle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        while (expected_px.size() != 0)
            report_failure("missing result", expected_px.pop_front(), '0);

        $display("Sent %0d pixels over %0d configured phases, frames 3x3 to 64 wide,",
                 items_sent, phase_count);
        $display("out-of-range sizes clamped; checked %0d pixels, %0d frame ends, %0d failures",
                 results_checked, frames_seen, fail_count);
        if (fail_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
